// ===== rtl/erma_pkg.sv =====
// Shared types and constants for the encoder rate moving average block.
// No dependencies; every other file refers to this package by scoped names.
package erma_pkg;

  localparam int SAMPLE_W = 20;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // take the sample, read the oldest ring entry
    logic update;    // adjust the sum, write the ring, advance slot and count
    logic div_prep;  // load the divider with the sum magnitude
    logic div_step;  // one restoring division step
    logic load_out;  // move the signed quotient into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_last;  // the current step is the final one
    logic out_free;  // the output register can take a new result this cycle
  } status_t;

endpackage

// ===== rtl/erma_sample_if.sv =====
// Input channel: valid/ready handshake carrying one rate sample.
// Depends on erma_pkg for the sample width.
interface erma_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [erma_pkg::SAMPLE_W-1:0] rate_sample;

  modport source (output valid, output rate_sample, input ready);
  modport sink   (input valid, input rate_sample, output ready);
endinterface

// ===== rtl/erma_result_if.sv =====
// Output channel: valid/ready handshake carrying the mean and the full flag.
// Depends on erma_pkg for the sample width.
interface erma_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [erma_pkg::SAMPLE_W-1:0] mean_rate;
  logic                               window_full;

  modport source (output valid, output mean_rate, output window_full, input ready);
  modport sink   (input valid, input mean_rate, input window_full, output ready);
endinterface

// ===== rtl/erma_ctrl.sv =====
// Controller state machine for the moving average block.
// Depends on erma_pkg for the command and status structs.
module erma_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  erma_pkg::status_t stat,
  output erma_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_PREP   = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.div_prep = 1'b1;
        state_next   = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        cmd.load_out = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/erma_dp.sv =====
// Datapath: sample ring memory, running sum, serial divider, output register.
// Depends on erma_pkg for the sample width and the command and status structs.
module erma_dp #(
  parameter int WINDOW = 50
) (
  input  logic                                clk,
  input  logic                                rst,
  input  erma_pkg::cmd_t                      cmd,
  output erma_pkg::status_t                   stat,
  input  logic signed [erma_pkg::SAMPLE_W-1:0] rate_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [erma_pkg::SAMPLE_W-1:0] mean_rate,
  output logic                                window_full
);

  localparam int SW     = erma_pkg::SAMPLE_W;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = SW + CNT_W;
  localparam int ITER_W = $clog2(SUM_W);

  logic [SW-1:0]           ring [WINDOW];
  logic signed [SW-1:0]    sample;
  logic signed [SW-1:0]    ring_q;
  logic [SLOT_W-1:0]       slot;
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0]        quo;
  logic [CNT_W-1:0]        rem;
  logic                    neg;
  logic [ITER_W-1:0]       iter;
  logic                    full;
  logic [CNT_W:0]          rem_sh;
  logic [CNT_W+1:0]        diff;
  logic                    take;
  logic [SUM_W-1:0]        quo_signed;

  assign full = (count == CNT_W'(WINDOW));

  // Ring memory: read the oldest entry on capture, write the new sample on update
  always_ff @(posedge clk) begin
    if (cmd.capture) ring_q <= ring[slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.update) ring[slot] <= sample;
  end

  always_comb begin
    sum_next = sum + SUM_W'(sample);
    if (full) sum_next = sum_next - SUM_W'(ring_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) sample <= rate_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      count <= '0;
      sum   <= '0;
    end else if (cmd.update) begin
      sum  <= sum_next;
      slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
      if (!full) count <= count + 1'b1;
    end
  end

  // Restoring division of the sum magnitude by the count, one bit a cycle
  assign rem_sh = {rem, quo[SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, count};
  assign take   = !diff[CNT_W+1];

  always_ff @(posedge clk) begin
    if (cmd.div_prep) begin
      neg  <= sum[SUM_W-1];
      quo  <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      rem  <= '0;
      iter <= '0;
    end else if (cmd.div_step) begin
      quo  <= {quo[SUM_W-2:0], take};
      rem  <= take ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      iter <= iter + 1'b1;
    end
  end

  assign stat.div_last = (iter == ITER_W'(SUM_W - 1));
  assign stat.out_free = !out_valid || out_ready;

  assign quo_signed = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mean_rate   <= quo_signed[SW-1:0];
      window_full <= full;
    end
  end

endmodule

// ===== rtl/encoder_rate_moving_average_top.sv =====
// Boxcar moving average of signed encoder rate samples (8 fraction bits).
// A sample is taken only in the idle state; capture, sum update and divider load
// precede the bit-serial divider, one quotient bit per cycle over the sum width,
// and the next sample waits until the result is loaded into the output register.
// Reset (synchronous, rst high) clears slot, count, sum and output valid;
// the ring memory is not cleared, since an entry's value is used only after it is written.
module encoder_rate_moving_average_top #(
  parameter int WINDOW = 50
) (
  input  logic          clk,
  input  logic          rst,
  erma_sample_if.sink   samples,
  erma_result_if.source results
);

  erma_pkg::cmd_t    cmd;
  erma_pkg::status_t stat;

  // Controller: sequences capture, update, divide and output load
  erma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: ring, running sum, divider and output register.
  // The output register lets the next sample transfer while a result waits.
  erma_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .rate_sample (samples.rate_sample),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .mean_rate   (results.mean_rate),
    .window_full (results.window_full)
  );

  // Commands are mutually exclusive
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.update, cmd.div_prep, cmd.div_step, cmd.load_out}))
    else $error("more than one datapath command at once");

  // A captured sample is folded into the sum in the following cycle
  a_capture_update: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.update)
    else $error("capture not followed by update");

  // The divider is loaded right after the sum changes
  a_update_prep: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> cmd.div_prep)
    else $error("update not followed by divider load");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!results.valid || results.ready))
    else $error("pending result overwritten");

endmodule
